@@ hw/rtl/iq_sample_format_converter_assert.svh @@
// Assertion macros used by the checker in iqfc_checker.sv.
`ifndef IQ_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH
`define IQ_SAMPLE_FORMAT_CONVERTER_ASSERT_SVH

// same-cycle implication
`define IQFC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define IQFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/iqfc_pkg.sv @@
`default_nettype none
package iqfc_pkg;

   typedef enum logic [2:0] {
      FMT_CF32 = 3'd0,
      FMT_CF64 = 3'd1,
      FMT_CI16 = 3'd2,
      FMT_CI32 = 3'd3,
      FMT_CU16 = 3'd4,
      FMT_CU32 = 3'd5,
      FMT_CI8  = 3'd6,
      FMT_CU8  = 3'd7
   } fmt_type;

   localparam logic CSR_SAMPLE_FORMAT = 1'b0;
   localparam logic CSR_BIG_ENDIAN    = 1'b1;

   localparam logic [62:0] CF64_LIMIT = 63'h412E848000000000; // 1e6

   // one component after decode: value = mag * 2^exp (plus repeating tail when dbl)
   typedef struct packed {
      logic               sign;
      logic               zero;
      logic               bad;
      logic               pass;
      logic [31:0]        pass_bits;
      logic               dbl;
      logic [63:0]        mag;
      logic [31:0]        fill;
      logic signed [12:0] exp;
   } comp_type;

   // one component in normalized form: leading one at m[63] weighs 2^exp
   typedef struct packed {
      logic               sign;
      logic               zero;
      logic               bad;
      logic               pass;
      logic [31:0]        pass_bits;
      logic               dbl;
      logic [63:0]        m;
      logic               sticky;
      logic               subn;
      logic signed [12:0] exp;
   } norm_type;

   typedef struct packed {
      comp_type i;
      comp_type q;
   } dec_pair_type;

   typedef struct packed {
      norm_type i;
      norm_type q;
   } norm_pair_type;

   function automatic comp_type decode(input logic [63:0] raw, input fmt_type fmt,
                                       input logic be);
      comp_type    c;
      logic [63:0] v64;
      logic [31:0] v32;
      logic [15:0] v16;
      logic [7:0]  v8;
      logic [15:0] a16;
      logic [31:0] a32;
      logic [7:0]  a8;
      logic [15:0] t16;
      logic [31:0] t32;
      logic [7:0]  t8;
      c = '0;
      for (int k = 0; k < 8; k++) begin
         v64[8*k +: 8] = be ? raw[8*(7-k) +: 8] : raw[8*k +: 8];
      end
      v32 = be ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw[31:0];
      v16 = be ? {raw[7:0], raw[15:8]} : raw[15:0];
      v8  = raw[7:0];
      a16 = v16[15] ? (16'h0 - v16) : v16;
      a32 = v32[31] ? (32'h0 - v32) : v32;
      a8  = v8[7] ? (8'h0 - v8) : v8;
      // |2v - (2^n - 1)| is odd, built from the low bits
      t16 = {v16[14:0] ^ {15{~v16[15]}}, 1'b1};
      t32 = {v32[30:0] ^ {31{~v32[31]}}, 1'b1};
      t8  = {v8[6:0] ^ {7{~v8[7]}}, 1'b1};
      case (fmt)
         FMT_CF32: begin
            c.pass      = 1'b1;
            c.pass_bits = v32;
            c.bad       = &v32[30:23];
         end
         FMT_CF64: begin
            c.bad  = (&v64[62:52]) || (v64[62:0] > CF64_LIMIT);
            c.sign = v64[63];
            c.zero = ~|v64[62:52];
            c.mag  = {1'b1, v64[51:0], 11'b0};
            c.exp  = $signed({2'b00, v64[62:52]}) - 13'sd1086;
         end
         FMT_CI16: begin
            c.sign = v16[15];
            c.zero = ~|v16;
            c.mag  = {16'h0, a16, 32'h0};
            c.exp  = -13'sd47;
         end
         FMT_CI32: begin
            c.sign = v32[31];
            c.zero = ~|v32;
            c.mag  = {a32, 32'h0};
            c.exp  = -13'sd63;
         end
         FMT_CI8: begin
            c.sign = v8[7];
            c.zero = ~|v8;
            c.mag  = {24'h0, a8, 32'h0};
            c.exp  = -13'sd39;
         end
         FMT_CU16: begin
            c.sign = ~v16[15];
            c.dbl  = 1'b1;
            c.fill = {t16, t16};
            c.mag  = {t16, t16, t16, t16};
            c.exp  = -13'sd64;
         end
         FMT_CU32: begin
            c.sign = ~v32[31];
            c.dbl  = 1'b1;
            c.fill = t32;
            c.mag  = {t32, t32};
            c.exp  = -13'sd64;
         end
         default: begin
            c.sign = ~v8[7];
            c.dbl  = 1'b1;
            c.fill = {4{t8}};
            c.mag  = {8{t8}};
            c.exp  = -13'sd64;
         end
      endcase
      return c;
   endfunction

   function automatic norm_type normalize(input comp_type c);
      norm_type    n;
      logic [5:0]  lz;
      logic [6:0]  sh;
      logic [63:0] fill_bits;
      lz = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (c.mag[i]) lz = 6'(63 - i);
      end
      // repeating fraction: bits shifted in come from the next block
      sh = 7'd32 - {1'b0, lz};
      fill_bits = (c.dbl && lz < 6'd32) ? ({32'h0, c.fill} >> sh) : 64'h0;
      n.sign      = c.sign;
      n.zero      = c.zero;
      n.bad       = c.bad;
      n.pass      = c.pass;
      n.pass_bits = c.pass_bits;
      n.dbl       = c.dbl;
      n.m         = (c.mag << lz) | fill_bits;
      n.sticky    = 1'b0;
      n.subn      = 1'b0;
      n.exp       = c.exp + 13'sd63 - $signed({7'b0, lz});
      return n;
   endfunction

   // round to double precision; the infinite tail is never zero
   function automatic norm_type dround(input norm_type a);
      norm_type    n;
      logic [53:0] sum;
      n = a;
      sum = {1'b0, a.m[63:11]} + {53'b0, a.m[10]};
      if (a.dbl) begin
         if (sum[53]) begin
            n.m   = {1'b1, 63'b0};
            n.exp = a.exp + 13'sd1;
         end else begin
            n.m = {sum[52:0], 11'b0};
         end
      end
      return n;
   endfunction

   function automatic norm_type denorm(input norm_type a);
      norm_type           n;
      logic signed [12:0] sh13;
      logic [5:0]         sh;
      n = a;
      sh13 = -13'sd126 - a.exp;
      sh = sh13[5:0];
      if (!a.pass && !a.zero && a.exp < -13'sd126) begin
         n.subn = 1'b1;
         if (sh13 > 13'sd63) begin
            n.sticky = |a.m;
            n.m      = 64'h0;
         end else begin
            n.sticky = |(a.m & ~({64{1'b1}} << sh));
            n.m      = a.m >> sh;
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] fround(input norm_type a);
      logic        up;
      logic [7:0]  bexp;
      logic [30:0] pack;
      up   = a.m[39] & ((|a.m[38:0]) | a.sticky | a.m[40]);
      bexp = a.subn ? 8'h0 : (a.exp[7:0] + 8'd127);
      pack = {bexp, a.m[62:40]} + {30'b0, up};
      if (a.pass) return a.pass_bits;
      if (a.zero) return {a.sign, 31'b0};
      return {a.sign, pack};
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/iqfc_decode.sv @@
`default_nettype none
module iqfc_decode (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire  [63:0]                 raw_i,
   input  wire  [63:0]                 raw_q,
   input  iqfc_pkg::fmt_type           fmt,
   input  wire                         big_endian,
   output logic                        out_valid,
   input  wire                         out_ready,
   output iqfc_pkg::dec_pair_type      out_data
);
   logic                   valid_ff;
   iqfc_pkg::dec_pair_type data_ff;
   iqfc_pkg::dec_pair_type data_in;

   assign in_ready = !valid_ff || out_ready;
   assign data_in.i = iqfc_pkg::decode(raw_i, fmt, big_endian);
   assign data_in.q = iqfc_pkg::decode(raw_q, fmt, big_endian);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/iqfc_norm.sv @@
`default_nettype none
module iqfc_norm (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  iqfc_pkg::dec_pair_type      in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output iqfc_pkg::norm_pair_type     out_data
);
   logic                    valid_ff;
   iqfc_pkg::norm_pair_type data_ff;
   iqfc_pkg::norm_pair_type data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign data_in.i = iqfc_pkg::normalize(in_data.i);
   assign data_in.q = iqfc_pkg::normalize(in_data.q);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

@@ hw/rtl/iqfc_round.sv @@
`default_nettype none
// two stages: rounding of the repeating fractions to double, then the
// right shift into the float subnormal range
module iqfc_round (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  iqfc_pkg::norm_pair_type     in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output iqfc_pkg::norm_pair_type     out_data
);
   logic                    dbl_valid_ff;
   logic                    sub_valid_ff;
   logic                    dbl_ready;
   iqfc_pkg::norm_pair_type dbl_ff;
   iqfc_pkg::norm_pair_type sub_ff;
   iqfc_pkg::norm_pair_type dbl_in;
   iqfc_pkg::norm_pair_type sub_in;

   assign dbl_ready = !sub_valid_ff || out_ready;
   assign in_ready  = !dbl_valid_ff || dbl_ready;

   assign dbl_in.i = iqfc_pkg::dround(in_data.i);
   assign dbl_in.q = iqfc_pkg::dround(in_data.q);
   assign sub_in.i = iqfc_pkg::denorm(dbl_ff.i);
   assign sub_in.q = iqfc_pkg::denorm(dbl_ff.q);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbl_valid_ff <= 1'b0;
         sub_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            dbl_valid_ff <= in_valid;
         end
         if (dbl_ready) begin
            sub_valid_ff <= dbl_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         dbl_ff <= dbl_in;
      end
      if (dbl_ready && dbl_valid_ff) begin
         sub_ff <= sub_in;
      end
   end

   assign out_valid = sub_valid_ff;
   assign out_data  = sub_ff;
endmodule
`default_nettype wire

@@ hw/rtl/iqfc_pack.sv @@
`default_nettype none
module iqfc_pack (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  iqfc_pkg::norm_pair_type     in_data,
   output logic                        out_valid,
   input  wire                         out_ready,
   output logic [31:0]                 i_value,
   output logic [31:0]                 q_value,
   output logic                        sample_invalid
);
   logic        valid_ff;
   logic [31:0] i_value_ff;
   logic [31:0] q_value_ff;
   logic        invalid_ff;
   logic [31:0] i_value_in;
   logic [31:0] q_value_in;
   logic        invalid_in;

   assign in_ready   = !valid_ff || out_ready;
   // a bad component zeroes both values
   assign invalid_in = in_data.i.bad || in_data.q.bad;
   assign i_value_in = invalid_in ? 32'h0 : iqfc_pkg::fround(in_data.i);
   assign q_value_in = invalid_in ? 32'h0 : iqfc_pkg::fround(in_data.q);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         i_value_ff <= i_value_in;
         q_value_ff <= q_value_in;
         invalid_ff <= invalid_in;
      end
   end

   assign out_valid      = valid_ff;
   assign i_value        = i_value_ff;
   assign q_value        = q_value_ff;
   assign sample_invalid = invalid_ff;
endmodule
`default_nettype wire

@@ hw/rtl/iq_sample_format_converter.sv @@
// Pipeline: an accepted req word passes through registered stages for decode,
// normalize, double rounding, subnormal shift and float rounding to rsp_valid.
// Throughput: one complex sample per cycle; every stage holds under backpressure.
// Reset (synchronous, active high) empties the pipeline and sets
// sample_format to cf32 and big_endian to 0.
`default_nettype none
module iq_sample_format_converter (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [63:0] req_raw_i,
   input  wire  [63:0] req_raw_q,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_i_value,
   output logic [31:0] rsp_q_value,
   output logic        rsp_sample_invalid,
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [2:0]  csr_wdata
);
   iqfc_pkg::fmt_type       sample_format_ff;
   logic                    big_endian_ff;
   logic                    dec_valid;
   logic                    dec_ready;
   iqfc_pkg::dec_pair_type  dec_data;
   logic                    norm_valid;
   logic                    norm_ready;
   iqfc_pkg::norm_pair_type norm_data;
   logic                    rnd_valid;
   logic                    rnd_ready;
   iqfc_pkg::norm_pair_type rnd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_format_ff <= iqfc_pkg::FMT_CF32;
         big_endian_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            iqfc_pkg::CSR_SAMPLE_FORMAT: sample_format_ff <= iqfc_pkg::fmt_type'(csr_wdata);
            iqfc_pkg::CSR_BIG_ENDIAN:    big_endian_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   iqfc_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .raw_i      (req_raw_i),
      .raw_q      (req_raw_q),
      .fmt        (sample_format_ff),
      .big_endian (big_endian_ff),
      .out_valid  (dec_valid),
      .out_ready  (dec_ready),
      .out_data   (dec_data)
   );

   iqfc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_data   (dec_data),
      .out_valid (norm_valid),
      .out_ready (norm_ready),
      .out_data  (norm_data)
   );

   iqfc_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (norm_valid),
      .in_ready  (norm_ready),
      .in_data   (norm_data),
      .out_valid (rnd_valid),
      .out_ready (rnd_ready),
      .out_data  (rnd_data)
   );

   iqfc_pack u_pack (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (rnd_valid),
      .in_ready       (rnd_ready),
      .in_data        (rnd_data),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .i_value        (rsp_i_value),
      .q_value        (rsp_q_value),
      .sample_invalid (rsp_sample_invalid)
   );
endmodule
`default_nettype wire

@@ hw/rtl/iqfc_checker.sv @@
`default_nettype none
`include "iq_sample_format_converter_assert.svh"
module iqfc_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_i_value,
   input wire [31:0] rsp_q_value,
   input wire        rsp_sample_invalid
);
   `IQFC_ASSERT_IMPLY(a_invalid_zero, clock, reset, rsp_valid && rsp_sample_invalid, rsp_i_value == 32'h0 && rsp_q_value == 32'h0, "rejected word carries nonzero values")
   `IQFC_ASSERT_IMPLY(a_finite_i, clock, reset, rsp_valid && !rsp_sample_invalid, rsp_i_value[30:23] != 8'hFF, "accepted word has non-finite I")
   `IQFC_ASSERT_IMPLY(a_finite_q, clock, reset, rsp_valid && !rsp_sample_invalid, rsp_q_value[30:23] != 8'hFF, "accepted word has non-finite Q")
   `IQFC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "response valid right after reset")
   `IQFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_i_value) && $stable(rsp_q_value), "stalled response changed")
endmodule

bind iq_sample_format_converter iqfc_checker u_iqfc_checker (.*);
`default_nettype wire

@@ tb/iq_sample_format_converter_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iq_sample_format_converter_tb;

   typedef struct {
      logic [31:0] i_value;
      logic [31:0] q_value;
      logic        invalid;
   } sample_out_type;

   typedef struct {
      iqfc_pkg::fmt_type fmt;
      logic              be;
      logic [63:0]       raw_i;
      logic [63:0]       raw_q;
      logic              typed;
      sample_out_type    want;
   } vec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_raw_i = '0;
   logic [63:0] req_raw_q = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_i_value;
   logic [31:0] rsp_q_value;
   logic        rsp_sample_invalid;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [2:0]  csr_wdata = '0;

   iqfc_pkg::fmt_type cur_fmt = iqfc_pkg::FMT_CF32;
   logic              cur_be = 1'b0;
   sample_out_type    pending[$];
   sample_out_type    typed_want[$];
   logic              typed_flag[$];
   int                mismatches = 0;
   int                rsp_count = 0;

   iq_sample_format_converter dut (.*);

   always #2 clock = ~clock;

   // double bit pattern to float32, round to nearest even, subnormals kept
   function automatic logic [31:0] to_single(input logic [63:0] b);
      int          e;
      int          ex;
      int          sh;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] half;
      logic        up;
      logic [7:0]  fe;
      logic [30:0] pack;
      e = int'(b[62:52]);
      if (e == 0) return {b[63], 31'b0};
      m = {11'b0, 1'b1, b[51:0]};
      ex = e - 1023;
      sh = (ex < -126) ? (-126 - ex) : 0;
      if (29 + sh > 60) return {b[63], 31'b0};
      q = m >> (29 + sh);
      r = m & ((64'd1 << (29 + sh)) - 64'd1);
      half = 64'd1 << (28 + sh);
      up = (r > half) || (r == half && q[0]);
      fe = (ex < -126) ? 8'd0 : 8'(ex + 127);
      pack = {fe, q[22:0]} + {30'b0, up};
      return {b[63], pack};
   endfunction

   function automatic logic [63:0] order_bytes(input logic [63:0] w, input int nb,
                                               input logic be);
      logic [63:0] r;
      r = '0;
      if (nb < 8) w = w & ((64'd1 << (8 * nb)) - 64'd1);
      if (!be) return w;
      for (int k = 0; k < nb; k++) r[8*k +: 8] = w[8*(nb-1-k) +: 8];
      return r;
   endfunction

   // one component; returns 0 when the sample must be rejected
   function automatic logic convert_comp(input logic [63:0] raw,
                                         input iqfc_pkg::fmt_type fmt,
                                         input logic be, output logic [31:0] f);
      logic [63:0] v;
      longint      s;
      real         d;
      f = '0;
      case (fmt)
         iqfc_pkg::FMT_CF32: begin
            v = order_bytes(raw, 4, be);
            if (&v[30:23]) return 1'b0;
            f = v[31:0];
         end
         iqfc_pkg::FMT_CF64: begin
            v = order_bytes(raw, 8, be);
            if (&v[62:52]) return 1'b0;
            d = $bitstoreal(v);
            if (!(d <= 1.0e6 && d >= -1.0e6)) return 1'b0;
            f = to_single(v);
         end
         iqfc_pkg::FMT_CI16: begin
            v = order_bytes(raw, 2, be);
            s = v[15] ? longint'(v) - 65536 : longint'(v);
            f = to_single($realtobits(real'(s) / 32768.0));
         end
         iqfc_pkg::FMT_CI32: begin
            v = order_bytes(raw, 4, be);
            s = v[31] ? longint'(v) - 64'sd4294967296 : longint'(v);
            f = to_single($realtobits(real'(s) / 2147483648.0));
         end
         iqfc_pkg::FMT_CU16: begin
            v = order_bytes(raw, 2, be);
            f = to_single($realtobits((real'(v) - 32767.5) / 32767.5));
         end
         iqfc_pkg::FMT_CU32: begin
            v = order_bytes(raw, 4, be);
            f = to_single($realtobits((real'(v) - 2147483647.5) / 2147483647.5));
         end
         iqfc_pkg::FMT_CI8: begin
            s = raw[7] ? longint'(raw[7:0]) - 256 : longint'(raw[7:0]);
            f = to_single($realtobits(real'(s) / 128.0));
         end
         default: begin
            // single-precision division: double then round is exact enough here
            f = to_single($realtobits((real'(raw[7:0]) - 127.5) / 127.5));
         end
      endcase
      return 1'b1;
   endfunction

   function automatic sample_out_type convert_sample(input iqfc_pkg::fmt_type fmt,
                                                     input logic be,
                                                     input logic [63:0] ri,
                                                     input logic [63:0] rq);
      sample_out_type o;
      logic [31:0]    fi;
      logic [31:0]    fq;
      logic           ok_i;
      logic           ok_q;
      ok_i = convert_comp(ri, fmt, be, fi);
      ok_q = convert_comp(rq, fmt, be, fq);
      if (ok_i && ok_q) begin
         o.i_value = fi; o.q_value = fq; o.invalid = 1'b0;
      end else begin
         o.i_value = '0; o.q_value = '0; o.invalid = 1'b1;
      end
      return o;
   endfunction

   // record each accepted word against the live register values
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         pending.insert(pending.size(),
                        convert_sample(cur_fmt, cur_be, req_raw_i, req_raw_q));
   end

   always @(posedge clock) begin
      sample_out_type w;
      logic           got;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output word %h %h %b",
                                           rsp_i_value, rsp_q_value, rsp_sample_invalid);
         end else begin
            w = pending.pop_front();
            got = typed_flag.size() > 0 ? typed_flag.pop_front() : 1'b0;
            if (got) begin
               // hand-entered value replaces the predicted one
               w = typed_want.pop_front();
            end
            if (w.i_value !== rsp_i_value || w.q_value !== rsp_q_value ||
                w.invalid !== rsp_sample_invalid) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: want i=%h q=%h inv=%b got i=%h q=%h inv=%b",
                           w.i_value, w.q_value, w.invalid,
                           rsp_i_value, rsp_q_value, rsp_sample_invalid);
            end
         end
      end
   end

   // output side: random stalls, no-stall stretches, one long hold-off
   initial begin
      int   w;
      logic held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (!held && rsp_count >= 300) begin
            held = 1'b1;
            w = 400;
         end else if ((rsp_count / 100) % 3 == 1) w = 0;
         else w = $urandom_range(0, 14);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic drain();
      // first let the last accepted word reach the queue
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_regs(input iqfc_pkg::fmt_type fmt, input logic be);
      drain();
      csr_we <= 1'b1; csr_index <= iqfc_pkg::CSR_SAMPLE_FORMAT; csr_wdata <= fmt;
      @(posedge clock);
      csr_index <= iqfc_pkg::CSR_BIG_ENDIAN; csr_wdata <= {2'b0, be};
      @(posedge clock);
      csr_we <= 1'b0;
      cur_fmt = fmt;
      cur_be = be;
   endtask

   task automatic send(input logic [63:0] ri, input logic [63:0] rq, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_i <= ri;
      req_raw_q <= rq;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // one component of a well-formed sample, mostly legal values
   function automatic logic [63:0] make_comp(input iqfc_pkg::fmt_type fmt,
                                             input logic be);
      logic [63:0] v;
      int          nb;
      v = rand64();
      nb = 8;
      case (fmt)
         iqfc_pkg::FMT_CF32: begin
            nb = 4;
            if ($urandom_range(0, 9) == 0) v[30:23] = 8'hFF;
            else if ($urandom_range(0, 4) == 0) v[30:23] = 8'h00;
         end
         iqfc_pkg::FMT_CF64: begin
            case ($urandom_range(0, 5))
               0: v[62:52] = 11'h7FF;
               1: v[62:52] = 11'(1023 - 126 - $urandom_range(0, 30));
               2: v[62:52] = 11'(1023 + 19);
               default: v[62:52] = 11'(1023 - $urandom_range(0, 40));
            endcase
         end
         iqfc_pkg::FMT_CI16, iqfc_pkg::FMT_CU16: nb = 2;
         iqfc_pkg::FMT_CI32, iqfc_pkg::FMT_CU32: nb = 4;
         default: nb = 1;
      endcase
      if (nb < 8) return (rand64() << (8 * nb)) | order_bytes(v, nb, be);
      return order_bytes(v, 8, be);
   endfunction

   vec_type tab[$];

   function automatic void add_row(input iqfc_pkg::fmt_type fmt, input logic be,
                                   input logic [63:0] ri, input logic [63:0] rq,
                                   input logic typed,
                                   input logic [31:0] wi, input logic [31:0] wq,
                                   input logic winv);
      vec_type r;
      r.fmt = fmt; r.be = be; r.raw_i = ri; r.raw_q = rq; r.typed = typed;
      r.want.i_value = wi; r.want.q_value = wq; r.want.invalid = winv;
      tab.insert(tab.size(), r);
   endfunction

   initial begin
      iqfc_pkg::fmt_type f;
      logic              b;
      int                gap;
      add_row(iqfc_pkg::FMT_CF32, 0, 64'h3F800000, 64'hFFFFFFFF_BF800000, 1,
              32'h3F800000, 32'hBF800000, 0);
      add_row(iqfc_pkg::FMT_CF32, 0, 64'h7FC00000, 64'h0, 1, 0, 0, 1);
      add_row(iqfc_pkg::FMT_CF32, 0, 64'h0, 64'hFF800000, 1, 0, 0, 1);
      add_row(iqfc_pkg::FMT_CF32, 1, 64'h0000803F, 64'h00000080, 1,
              32'h3F800000, 32'h80000000, 0);
      add_row(iqfc_pkg::FMT_CF64, 0, 64'h412E848000000000, 64'hC12E848000000000, 1,
              32'h49742400, 32'hC9742400, 0);
      add_row(iqfc_pkg::FMT_CF64, 0, 64'h412E848000000001, 64'h0, 1, 0, 0, 1);
      add_row(iqfc_pkg::FMT_CF64, 0, 64'h0, 64'h7FF0000000000000, 1, 0, 0, 1);
      add_row(iqfc_pkg::FMT_CF64, 0, 64'h3FB999999999999A, 64'h0000000000000001, 0,
              0, 0, 0);
      add_row(iqfc_pkg::FMT_CF64, 0, 64'h380FFFFFF0000000, 64'h36A0000000000000, 0,
              0, 0, 0);
      add_row(iqfc_pkg::FMT_CF64, 1, 64'h000000000000F03F, 64'h0, 1,
              32'h3F800000, 0, 0);
      add_row(iqfc_pkg::FMT_CI16, 0, 64'hABCD_0000_0000_8000, 64'h7FFF, 1,
              32'hBF800000, 32'h3F7FFE00, 0);
      add_row(iqfc_pkg::FMT_CI16, 1, 64'h0080, 64'h0, 1, 32'hBF800000, 32'h0, 0);
      add_row(iqfc_pkg::FMT_CI32, 0, 64'h80000000, 64'h7FFFFFFF, 1,
              32'hBF800000, 32'h3F800000, 0);
      add_row(iqfc_pkg::FMT_CI32, 1, 64'h01000000, 64'hFFFFFFFF, 0, 0, 0, 0);
      add_row(iqfc_pkg::FMT_CU16, 0, 64'hFFFF, 64'h0, 1, 32'h3F800000, 32'hBF800000, 0);
      add_row(iqfc_pkg::FMT_CU16, 1, 64'h0080, 64'h7FFF, 0, 0, 0, 0);
      add_row(iqfc_pkg::FMT_CU32, 0, 64'hFFFFFFFF, 64'h0, 1,
              32'h3F800000, 32'hBF800000, 0);
      add_row(iqfc_pkg::FMT_CU32, 1, 64'h00000080, 64'h7FFFFFFF, 0, 0, 0, 0);
      add_row(iqfc_pkg::FMT_CI8, 1, 64'hFFFF_FF80, 64'h7F, 1,
              32'hBF800000, 32'h3F7E0000, 0);
      add_row(iqfc_pkg::FMT_CU8, 1, 64'hFFFF_FFFF, 64'h0, 1,
              32'h3F800000, 32'hBF800000, 0);
      add_row(iqfc_pkg::FMT_CU8, 0, 64'h80, 64'h7F, 0, 0, 0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (tab[k]) begin
         if (tab[k].fmt != cur_fmt || tab[k].be != cur_be) begin
            req_valid <= 1'b0;
            set_regs(tab[k].fmt, tab[k].be);
         end
         typed_flag.insert(typed_flag.size(), tab[k].typed);
         if (tab[k].typed) typed_want.insert(typed_want.size(), tab[k].want);
         send(tab[k].raw_i, tab[k].raw_q, $urandom_range(0, 3));
      end
      req_valid <= 1'b0;

      for (int ph = 0; ph < 16; ph++) begin
         f = iqfc_pkg::fmt_type'(ph < 8 ? ph : $urandom_range(0, 7));
         b = (ph < 8) ? ph[0] : 1'($urandom_range(0, 1));
         set_regs(f, b);
         for (int n = 0; n < 50; n++) begin
            gap = (ph % 4 == 2) ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 7) == 0) send(rand64(), rand64(), gap);
            else send(make_comp(f, b), make_comp(f, b), gap);
         end
         req_valid <= 1'b0;
      end
      drain();
      if (mismatches == 0 && pending.size() == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
